// ===== rtl/core/rea_pkg.sv =====
// Shared types, constants and helper functions for the rotary encoder accelerator.
package rea_pkg;

	// Default widths of the position and velocity state
	localparam int VALUE_BITS_DEF = 16;
	localparam int SPEED_BITS_DEF = 16;

	// Fixed behaviour constants
	localparam int PLAIN_SPEED = 1500;
	localparam int DECAY_STEP  = 2;
	localparam int VEL_INC     = 2;
	localparam int CURVE_LEN   = 5;
	localparam int GAIN_BITS   = 9;

	localparam int CURVE_TAB [CURVE_LEN] = '{VEL_INC * 8, VEL_INC * 10, VEL_INC * 15,
		VEL_INC * 30, VEL_INC * 50};

	// Port widths
	localparam int OUT_VALUE_BITS = 16;
	localparam int OUT_SPEED_BITS = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int LIMIT_BITS     = 15;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_VELOCITY_LIMIT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_VALUE_FLOOR    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_VALUE_CEILING  = 2'd3;

	// Decoded direction codes
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_CW   = 2'b01;
	localparam logic [1:0] DIR_CCW  = 2'b11;

	typedef struct packed {
		logic                      accel_enable;
		logic [LIMIT_BITS-1:0]     velocity_limit;
		logic [OUT_VALUE_BITS-1:0] value_floor;
		logic [OUT_VALUE_BITS-1:0] value_ceiling;
	} cfg_t;

	// Both negative patterns count as counterclockwise
	function automatic logic [1:0] dir_decode(input logic [1:0] raw);
		logic [1:0] d;
		case (raw) inside
			2'b10, 2'b11: d = DIR_CCW;
			2'b01:        d = DIR_CW;
			default:      d = DIR_NONE;
		endcase
		return d;
	endfunction

	// (idx + 1) mod 5 for any 3-bit index
	function automatic logic [2:0] next_index(input logic [2:0] idx);
		logic [2:0] n;
		if (idx >= 3'd4) n = idx - 3'd4;
		else             n = idx + 3'd1;
		return n;
	endfunction

	// curve[idx] * idx, zero outside the curve
	function automatic logic [GAIN_BITS-1:0] curve_gain(input logic [2:0] idx);
		logic [GAIN_BITS-1:0] g;
		if (int'(idx) < CURVE_LEN) g = GAIN_BITS'(CURVE_TAB[idx] * int'(idx));
		else                       g = '0;
		return g;
	endfunction

endpackage

// ===== rtl/core/rotary_encoder_accelerator_core.sv =====
// Top level of the rotary encoder accelerator: input stage, state and result register.
//
// Usage
//  - Input channel (in_valid/in_ready, step_dir): one detent item per handshake,
//    step_dir 0 = no movement, 1 = clockwise, 2 or 3 = counterclockwise.
//  - Result channel (out_valid/out_ready): one item per input item, in order,
//    carrying position_value, value_changed and the signed speed_now.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 accel
//    enable, 1 velocity limit, 2 value floor, 3 value ceiling. cfg_ready is
//    always high; write only while no items are in flight.
//  - Path: an accepted item waits in the input stage, is computed from the state
//    as it moves into the result register, and is shown on the result ports from then on.
//  - Throughput: one item per cycle while out_ready is high; the velocity/position
//    update is one pass of logic from the input stage into result register and state.
//  - Reset (arst_n low): config returns to accel on, limit 1500, floor 0,
//    ceiling 65535; position, velocity, curve index and last direction go to
//    zero; both stages empty.
//  - Stall: a waiting result holds; the input stage takes one more item and
//    then in_ready falls until out_ready returns.
module rotary_encoder_accelerator_core #(
	parameter int VALUE_BITS = rea_pkg::VALUE_BITS_DEF,
	parameter int SPEED_BITS = rea_pkg::SPEED_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [1:0]                        step_dir,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [rea_pkg::OUT_VALUE_BITS-1:0]       position_value,
	output logic                                     value_changed,
	output logic signed [rea_pkg::OUT_SPEED_BITS-1:0] speed_now,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [rea_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [rea_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
	import rea_pkg::*;

	cfg_t cfg;

	// Input stage
	logic       valid_s1;
	logic [1:0] step_s1;

	// Result stage
	logic                              valid_s2;
	logic [OUT_VALUE_BITS-1:0]         pos_s2;
	logic                              changed_s2;
	logic signed [OUT_SPEED_BITS-1:0]  speed_s2;

	// Encoder state
	logic [VALUE_BITS-1:0]        pos_q;
	logic signed [SPEED_BITS-1:0] speed_q;
	logic [2:0]                   idx_q;
	logic [1:0]                   last_dir_q;

	logic [VALUE_BITS-1:0]        pos_next;
	logic signed [SPEED_BITS-1:0] speed_next;
	logic [2:0]                   idx_next;
	logic [1:0]                   last_dir_next;
	logic                         changed;

	logic advance;

	assign cfg_ready = 1'b1;

	rea_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rea_update #(
		.VALUE_BITS (VALUE_BITS),
		.SPEED_BITS (SPEED_BITS)
	) u_update (
		.cfg           (cfg),
		.step_raw      (step_s1),
		.pos           (pos_q),
		.speed         (speed_q),
		.idx           (idx_q),
		.last_dir      (last_dir_q),
		.pos_next      (pos_next),
		.speed_next    (speed_next),
		.idx_next      (idx_next),
		.last_dir_next (last_dir_next),
		.changed       (changed)
	);

	// The held item moves on whenever the result register is free or emptying
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			step_s1 <= step_dir;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result payload: position zero-extended or cut to 16 bits, speed sign-extended or cut
	always_ff @(posedge clk) begin
		if (advance) begin
			pos_s2     <= OUT_VALUE_BITS'(pos_next);
			changed_s2 <= changed;
			speed_s2   <= OUT_SPEED_BITS'(speed_next);
		end
	end

	// State is updated exactly once per item, as it enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			speed_q    <= '0;
			idx_q      <= '0;
			last_dir_q <= DIR_NONE;
		end else if (advance) begin
			pos_q      <= pos_next;
			speed_q    <= speed_next;
			idx_q      <= idx_next;
			last_dir_q <= last_dir_next;
		end
	end

	assign out_valid      = valid_s2;
	assign position_value = pos_s2;
	assign value_changed  = changed_s2;
	assign speed_now      = speed_s2;

endmodule

// ===== rtl/core/rea_cfg_regs.sv =====
// Configuration register bank of the rotary encoder accelerator.
module rea_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [rea_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rea_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output rea_pkg::cfg_t                      cfg
);
	import rea_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_enable   <= 1'b1;
			cfg_q.velocity_limit <= LIMIT_BITS'(PLAIN_SPEED);
			cfg_q.value_floor    <= '0;
			cfg_q.value_ceiling  <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ACCEL_ENABLE:   cfg_q.accel_enable   <= cfg_data[0];
				CFG_VELOCITY_LIMIT: cfg_q.velocity_limit <= cfg_data[LIMIT_BITS-1:0];
				CFG_VALUE_FLOOR:    cfg_q.value_floor    <= cfg_data[OUT_VALUE_BITS-1:0];
				CFG_VALUE_CEILING:  cfg_q.value_ceiling  <= cfg_data[OUT_VALUE_BITS-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/rea_update.sv =====
// Next-state logic: velocity, curve index, direction and clamped position for one item.
module rea_update #(
	parameter int VALUE_BITS = rea_pkg::VALUE_BITS_DEF,
	parameter int SPEED_BITS = rea_pkg::SPEED_BITS_DEF
) (
	input  rea_pkg::cfg_t                 cfg,
	input  logic [1:0]                    step_raw,
	input  logic [VALUE_BITS-1:0]         pos,
	input  logic signed [SPEED_BITS-1:0]  speed,
	input  logic [2:0]                    idx,
	input  logic [1:0]                    last_dir,
	output logic [VALUE_BITS-1:0]         pos_next,
	output logic signed [SPEED_BITS-1:0]  speed_next,
	output logic [2:0]                    idx_next,
	output logic [1:0]                    last_dir_next,
	output logic                          changed
);
	import rea_pkg::*;

	localparam int MW = (VALUE_BITS > SPEED_BITS) ? VALUE_BITS : SPEED_BITS;
	localparam int AW = ((MW > OUT_VALUE_BITS) ? MW : OUT_VALUE_BITS) + 2;

	localparam logic signed [SPEED_BITS:0] SMAX = {2'b00, {(SPEED_BITS-1){1'b1}}};
	localparam logic signed [SPEED_BITS:0] SMIN = {2'b11, {(SPEED_BITS-1){1'b0}}};
	localparam logic signed [SPEED_BITS-1:0] DECAY_S = SPEED_BITS'(DECAY_STEP);
	localparam logic signed [SPEED_BITS-1:0] PLAIN_S = SPEED_BITS'(PLAIN_SPEED);

	logic [1:0] dir;
	logic       moved;
	logic       same_dir;

	assign dir      = dir_decode(step_raw);
	assign moved    = (dir != DIR_NONE);
	assign same_dir = (last_dir == dir);

	// Velocity, curve index and direction
	always_comb begin
		logic signed [SPEED_BITS:0] base;
		logic signed [SPEED_BITS:0] gain_s;
		logic signed [SPEED_BITS:0] sum;
		logic [2:0]                 idx_n;

		idx_n  = same_dir ? next_index(idx) : 3'd0;
		base   = same_dir ? (SPEED_BITS+1)'(speed) : '0;
		gain_s = signed'((SPEED_BITS+1)'(curve_gain(idx_n)));
		if (dir == DIR_CCW) gain_s = -gain_s;
		sum = base + gain_s;

		idx_next      = idx;
		last_dir_next = last_dir;
		if (!cfg.accel_enable) begin
			if (dir == DIR_CW)       speed_next = PLAIN_S;
			else if (dir == DIR_CCW) speed_next = -PLAIN_S;
			else                     speed_next = '0;
		end else if (!moved) begin
			if (speed >= DECAY_S)       speed_next = speed - DECAY_S;
			else if (speed <= -DECAY_S) speed_next = speed + DECAY_S;
			else                        speed_next = '0;
		end else begin
			idx_next      = idx_n;
			last_dir_next = dir;
			if (sum > SMAX)      speed_next = SMAX[SPEED_BITS-1:0];
			else if (sum < SMIN) speed_next = SMIN[SPEED_BITS-1:0];
			else                 speed_next = sum[SPEED_BITS-1:0];
		end
	end

	// Position: limit the step, then clamp to the window and to the value width
	always_comb begin
		logic signed [AW-1:0] lim_w;
		logic signed [AW-1:0] v_w;
		logic signed [AW-1:0] pos_w;
		logic signed [AW-1:0] nv_w;
		logic signed [AW-1:0] floor_w;
		logic signed [AW-1:0] ceil_w;
		logic signed [AW-1:0] vmax_w;

		lim_w   = signed'(AW'(cfg.velocity_limit));
		v_w     = AW'(speed_next);
		pos_w   = signed'(AW'(pos));
		floor_w = signed'(AW'(cfg.value_floor));
		ceil_w  = signed'(AW'(cfg.value_ceiling));
		vmax_w  = signed'(AW'({VALUE_BITS{1'b1}}));

		if (v_w > lim_w)  v_w = lim_w;
		if (v_w < -lim_w) v_w = -lim_w;
		nv_w = pos_w + v_w;
		if (nv_w < floor_w)     nv_w = floor_w;
		else if (nv_w > ceil_w) nv_w = ceil_w;
		if (nv_w > vmax_w)      nv_w = vmax_w;
		if (nv_w < 0)           nv_w = '0;

		pos_next = moved ? nv_w[VALUE_BITS-1:0] : pos;
	end

	assign changed = (pos_next != pos);

endmodule

// ===== rtl/core/rea_checker.sv =====
// Port-level checker for the rotary encoder accelerator, bound to the top level.
module rea_checker (
	input logic                                      clk,
	input logic                                      arst_n,
	input logic                                      in_valid,
	input logic                                      in_ready,
	input logic                                      out_valid,
	input logic                                      out_ready,
	input logic [rea_pkg::OUT_VALUE_BITS-1:0]        position_value,
	input logic                                      value_changed,
	input logic signed [rea_pkg::OUT_SPEED_BITS-1:0] speed_now
);
	import rea_pkg::*;

	logic [2:0]                pending_q;
	logic [OUT_VALUE_BITS-1:0] last_pos_q;
	logic                      in_acc;
	logic                      out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			last_pos_q <= '0;
		end else begin
			if (in_acc && !out_acc)      pending_q <= pending_q + 3'd1;
			else if (!in_acc && out_acc) pending_q <= pending_q - 3'd1;
			if (out_acc) last_pos_q <= position_value;
		end
	end

	// A stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position_value)
			&& $stable(value_changed) && $stable(speed_now))
		else $error("result changed while stalled");

	// No result without an accepted item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result with no item in flight");

	// At most two items in flight: input stage and result register
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd2 && !out_acc |-> !in_ready)
		else $error("item accepted with both stages full");

	// The change flag agrees with the previous delivered position
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> value_changed == (position_value != last_pos_q))
		else $error("value_changed disagrees with position");

endmodule

bind rotary_encoder_accelerator_core rea_checker u_rea_checker (.*);
